/* sv/nrd_pkg.sv */
// Package: shared types, constants and filter taps for the noise RSSI block
package nrd_pkg;
	localparam int NRD_BLOCK_SAMPLES = 160;
	localparam int NRD_TAPS = 23;
	localparam int NRD_POS_W = 8;
	localparam int NRD_ENERGY_W = 48;
	localparam int NRD_CFG_IDX_W = 2;
	localparam int NRD_CFG_DATA_W = 16;
	localparam logic [15:0] NRD_CALIB_RESET = 16'd3328;
	localparam logic [15:0] NRD_GAIN_UNITY = 16'd4096;
	localparam logic [15:0] NRD_CALIB_MIN = 16'd256;

	typedef enum logic [NRD_CFG_IDX_W-1:0] {
		CFG_CALIB  = 2'd0,
		CFG_DEEMPH = 2'd1,
		CFG_GAIN   = 2'd2
	} nrd_cfg_idx_t;

	typedef struct packed {
		logic [15:0] calib_divisor;
		logic        deemph_enable;
		logic [15:0] rx_gain;
	} nrd_cfg_t;

	typedef struct packed {
		logic signed [15:0]        x;
		logic                      frame_end;
		logic [NRD_ENERGY_W-1:0]   energy;
	} nrd_item_t;

	function automatic logic signed [15:0] nrd_tap(input logic [4:0] i);
		logic signed [15:0] t;
		unique case (i)
			5'd0, 5'd22:  t = 16'sd128;
			5'd1, 5'd21:  t = 16'sd402;
			5'd2, 5'd20:  t = -16'sd1225;
			5'd3, 5'd19:  t = 16'sd1927;
			5'd4, 5'd18:  t = -16'sd1674;
			5'd5, 5'd17:  t = 16'sd164;
			5'd6, 5'd16:  t = 16'sd1729;
			5'd7, 5'd15:  t = -16'sd2249;
			5'd8, 5'd14:  t = 16'sd54;
			5'd9, 5'd13:  t = 16'sd4461;
			5'd10, 5'd12: t = -16'sd9036;
			5'd11:        t = 16'sd10962;
			default:      t = 16'sd0;
		endcase
		return t;
	endfunction
endpackage

/* sv/nrd_if.sv */
// Interfaces: sample input channel and result output channel
interface sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] audio_out;
	logic [7:0]         rssi;
	logic               rssi_valid;
	modport source (output valid, output audio_out, output rssi, output rssi_valid, input ready);
	modport sink (input valid, input audio_out, input rssi, input rssi_valid, output ready);
endinterface

/* sv/noise_rssi_and_deemphasis_top.sv */
// Top level: noise RSSI measurement and de-emphasis/gain audio path
// Usage:
//   in_ch  : one Q15 sample per transaction (valid/ready).
//   out_ch : one result per sample: processed audio, and rssi with
//            rssi_valid high on the last sample of each frame.
//   cfg_we/cfg_index/cfg_data : register writes (0 calib_divisor,
//            1 deemph_enable, 2 rx_gain); write only while idle.
// Structure:
//   The front end runs each sample through a single shared
//   23-tap multiply-accumulate and takes no new sample until it is done.
//   The back end applies optional de-emphasis and gain to each sample;
//   on a frame end it adds a 24-step square root and a 48-step serial
//   divide. A two-entry queue between them absorbs that work.
// Reset clears filter history, energy, frame position, de-emphasis state
// and restores register defaults. When out_ch stalls the result is held
// in the output register; the queue fills and then in_ch.ready drops.
module noise_rssi_and_deemphasis_top #(
	parameter int BLOCK_SAMPLES = nrd_pkg::NRD_BLOCK_SAMPLES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sample_if.sink                             in_ch,
	result_if.source                           out_ch,
	input  logic                               cfg_we,
	input  logic [nrd_pkg::NRD_CFG_IDX_W-1:0]  cfg_index,
	input  logic [nrd_pkg::NRD_CFG_DATA_W-1:0] cfg_data
);
	import nrd_pkg::*;

	nrd_cfg_t  cfg_q;
	nrd_item_t push_item;
	nrd_item_t pop_item;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calib_divisor <= NRD_CALIB_RESET;
			cfg_q.deemph_enable <= 1'b0;
			cfg_q.rx_gain <= NRD_GAIN_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CALIB:  cfg_q.calib_divisor <= cfg_data;
				CFG_DEEMPH: cfg_q.deemph_enable <= cfg_data[0];
				CFG_GAIN:   cfg_q.rx_gain <= cfg_data;
				default:    ;
			endcase
		end
	end

	nrd_front #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.push_item (push_item),
		.push      (push),
		.q_full    (q_full)
	);

	nrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	nrd_back #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_item (pop_item),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_ch   (out_ch)
	);
endmodule

/* sv/nrd_front.sv */
// Front end: high-pass FIR MAC, energy accumulation and frame tracking
module nrd_front #(
	parameter int BLOCK_SAMPLES = nrd_pkg::NRD_BLOCK_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	sample_if.sink            in_ch,
	output nrd_pkg::nrd_item_t push_item,
	output logic              push,
	input  logic              q_full
);
	import nrd_pkg::*;

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MAC  = 5'b00010,
		F_Y    = 5'b00100,
		F_SQ   = 5'b01000,
		F_PUSH = 5'b10000
	} f_state_t;

	f_state_t                 state_q;
	logic signed [15:0]       x_q;
	logic signed [15:0]       hist_q [NRD_TAPS-1];
	logic [4:0]               cnt_q;
	logic signed [31:0]       prod_s1;
	logic                     pv_s1;
	logic signed [33:0]       acc_q;
	logic signed [17:0]       y_q;
	logic [31:0]              sq_q;
	logic [NRD_ENERGY_W-1:0]  energy_q;
	logic [NRD_POS_W-1:0]     pos_q;
	logic signed [15:0]       smp;
	logic signed [35:0]       ysq;
	logic [NRD_ENERGY_W-1:0]  energy_new;
	logic                     frame_end;

	assign in_ch.ready = (state_q == F_IDLE);
	assign smp = (cnt_q == 5'd0) ? x_q : hist_q[cnt_q - 5'd1];
	assign ysq = y_q * y_q;
	assign energy_new = energy_q + {16'd0, sq_q};
	assign frame_end = ({1'b0, pos_q} + 9'd1) >= 9'(BLOCK_SAMPLES);

	assign push = (state_q == F_PUSH) && !q_full;
	assign push_item.x = x_q;
	assign push_item.frame_end = frame_end;
	assign push_item.energy = energy_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
			pv_s1 <= 1'b0;
			energy_q <= '0;
			pos_q <= '0;
			for (int i = 0; i < NRD_TAPS - 1; i++) hist_q[i] <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						x_q <= in_ch.sample_in;
						cnt_q <= '0;
						acc_q <= '0;
						pv_s1 <= 1'b0;
						state_q <= F_MAC;
					end
				end
				F_MAC: begin
					if (pv_s1) acc_q <= acc_q + 34'(prod_s1);
					if (cnt_q != 5'(NRD_TAPS)) begin
						prod_s1 <= nrd_tap(cnt_q) * smp;
						pv_s1 <= 1'b1;
						cnt_q <= cnt_q + 5'd1;
					end else begin
						pv_s1 <= 1'b0;
						if (!pv_s1) state_q <= F_Y;
					end
				end
				F_Y: begin
					y_q <= 18'((acc_q + 34'sd16384) >>> 15);
					for (int i = NRD_TAPS - 2; i > 0; i--) hist_q[i] <= hist_q[i-1];
					hist_q[0] <= x_q;
					state_q <= F_SQ;
				end
				F_SQ: begin
					sq_q <= ysq[31:0];
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						if (frame_end) begin
							energy_q <= '0;
							pos_q <= '0;
						end else begin
							energy_q <= energy_new;
							pos_q <= pos_q + 1'b1;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

/* sv/nrd_queue.sv */
// Two-entry queue between front end and back end
module nrd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  nrd_pkg::nrd_item_t push_item,
	input  logic               pop,
	output nrd_pkg::nrd_item_t pop_item,
	output logic               full,
	output logic               empty
);
	import nrd_pkg::*;

	nrd_item_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* sv/nrd_back.sv */
// Back end: de-emphasis, gain, RMS/RSSI computation and output register
module nrd_back #(
	parameter int BLOCK_SAMPLES = nrd_pkg::NRD_BLOCK_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nrd_pkg::nrd_cfg_t  cfg,
	input  nrd_pkg::nrd_item_t pop_item,
	input  logic               q_empty,
	output logic               pop,
	result_if.source           out_ch
);
	import nrd_pkg::*;

	localparam logic [7:0] BS8 = 8'(BLOCK_SAMPLES);

	typedef enum logic [8:0] {
		B_IDLE = 9'b000000001,
		B_DE1  = 9'b000000010,
		B_DE2  = 9'b000000100,
		B_G1   = 9'b000001000,
		B_G2   = 9'b000010000,
		B_SQRT = 9'b000100000,
		B_DIV  = 9'b001000000,
		B_RSSI = 9'b010000000,
		B_OUT  = 9'b100000000
	} b_state_t;

	b_state_t                 state_q;
	nrd_item_t                item_q;
	logic signed [23:0]       v_q;
	logic signed [23:0]       dstate_q;
	logic signed [37:0]       m1_s1;
	logic signed [40:0]       m2_s1;
	logic signed [40:0]       gp_s1;
	logic signed [15:0]       audio_q;
	logic [7:0]               rssi_q;
	logic [47:0]              num_q;
	logic [15:0]              rem_q;
	logic [15:0]              den_q;
	logic [5:0]               dcnt_q;
	logic [47:0]              sn_q;
	logic [47:0]              res_q;
	logic [47:0]              bit_q;
	logic [4:0]               scnt_q;
	logic                     ovalid_q;
	logic signed [15:0]       oaudio_q;
	logic [7:0]               orssi_q;
	logic                     orv_q;

	logic [16:0]              rem_sh;
	logic                     rem_ge;
	logic [48:0]              s_base;
	logic [56:0]              s_trial;
	logic signed [41:0]       de_sum;
	logic signed [41:0]       g_sum;
	logic signed [24:0]       u_sum;
	logic [15:0]              d_eff;
	logic                     load_out;

	function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
		logic signed [15:0] r;
		if (v > 26'sd32767) r = 16'sd32767;
		else if (v < -26'sd32768) r = -16'sd32768;
		else r = v[15:0];
		return r;
	endfunction

	assign pop = (state_q == B_IDLE) && !q_empty;
	assign rem_sh = {rem_q, num_q[47]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	// root of energy/N found as the largest r with N*r*r <= energy
	assign s_base = {1'b0, res_q} + {1'b0, bit_q};
	assign s_trial = {8'd0, s_base} * {49'd0, BS8};
	assign de_sum = 42'(m1_s1) + 42'(m2_s1) + 42'sd32768;
	assign g_sum = 42'(gp_s1) + 42'sd524288;
	assign u_sum = 25'(v_q) + 25'sd128;
	assign d_eff = (cfg.calib_divisor < NRD_CALIB_MIN) ? NRD_CALIB_MIN : cfg.calib_divisor;
	assign load_out = (state_q == B_OUT) && (!ovalid_q || out_ch.ready);

	assign out_ch.valid = ovalid_q;
	assign out_ch.audio_out = oaudio_q;
	assign out_ch.rssi = orssi_q;
	assign out_ch.rssi_valid = orv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			dstate_q <= '0;
			ovalid_q <= 1'b0;
			dcnt_q <= '0;
			scnt_q <= '0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						item_q <= pop_item;
						v_q <= {pop_item.x, 8'd0};
						state_q <= cfg.deemph_enable ? B_DE1 : B_G1;
					end
				end
				B_DE1: begin
					m1_s1 <= 38'sd13107 * 38'(v_q);
					m2_s1 <= 41'sd52429 * 41'(dstate_q);
					state_q <= B_DE2;
				end
				B_DE2: begin
					v_q <= de_sum[39:16];
					dstate_q <= de_sum[39:16];
					state_q <= B_G1;
				end
				B_G1: begin
					gp_s1 <= 41'(v_q) * 41'(signed'({1'b0, cfg.rx_gain}));
					state_q <= B_G2;
				end
				B_G2: begin
					if (cfg.rx_gain != NRD_GAIN_UNITY) audio_q <= sat16(26'(g_sum >>> 20));
					else audio_q <= sat16(26'(u_sum >>> 8));
					if (item_q.frame_end) begin
						sn_q <= item_q.energy;
						res_q <= '0;
						bit_q <= 48'd1 << 46;
						scnt_q <= 5'd24;
						state_q <= B_SQRT;
					end else begin
						rssi_q <= '0;
						state_q <= B_OUT;
					end
				end
				B_SQRT: begin
					if (scnt_q == 5'd0) begin
						num_q <= {res_q[39:0], 8'd0} + {32'd0, d_eff} - 48'd1;
						den_q <= d_eff;
						rem_q <= '0;
						dcnt_q <= 6'd48;
						state_q <= B_DIV;
					end else begin
						if ({9'd0, sn_q} >= s_trial) begin
							sn_q <= sn_q - s_trial[47:0];
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
						scnt_q <= scnt_q - 5'd1;
					end
				end
				B_DIV: begin
					rem_q <= rem_ge ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
					num_q <= {num_q[46:0], rem_ge};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) state_q <= B_RSSI;
				end
				B_RSSI: begin
					rssi_q <= (num_q > 48'd245) ? 8'd10 : 8'(9'd255 - {1'b0, num_q[7:0]});
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (load_out) begin
						oaudio_q <= audio_q;
						orssi_q <= rssi_q;
						orv_q <= item_q.frame_end;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* dv/tb_noise_rssi_and_deemphasis_top.sv */
// Testbench: scoreboard-checked regression of the noise RSSI and de-emphasis block
`timescale 1ns / 100ps

class nrd_scoreboard;
	localparam int NT = nrd_pkg::NRD_TAPS;
	logic [15:0] calib;
	logic        deemph;
	logic [15:0] gain;
	logic signed [15:0] hist [NT-1];
	int unsigned pos;
	logic [47:0] energy;
	logic signed [23:0] de_state;
	logic signed [15:0] exp_audio [$];
	logic [7:0]         exp_rssi [$];
	logic               exp_rv [$];
	int errors;
	int frames;

	function new();
		errors = 0;
		frames = 0;
		calib = nrd_pkg::NRD_CALIB_RESET;
		deemph = 1'b0;
		gain = nrd_pkg::NRD_GAIN_UNITY;
		foreach (hist[i]) hist[i] = '0;
		pos = 0;
		energy = '0;
		de_state = '0;
	endfunction

	function void write_reg(nrd_pkg::nrd_cfg_idx_t idx, logic [15:0] val);
		case (idx)
			nrd_pkg::CFG_CALIB:  calib = val;
			nrd_pkg::CFG_DEEMPH: deemph = val[0];
			nrd_pkg::CFG_GAIN:   gain = val;
			default: ;
		endcase
	endfunction

	function longint fshift(longint v, int sh);
		return v >>> sh;
	endfunction

	function longint sat(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function longint unsigned root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function void note_sample(logic signed [15:0] x);
		longint acc, y, v;
		longint unsigned d, r, q;
		logic [7:0] rs;
		logic rv;
		acc = longint'(nrd_pkg::nrd_tap(5'd0)) * x;
		for (int i = 1; i < NT; i++)
			acc += longint'(nrd_pkg::nrd_tap(i[4:0])) * hist[i-1];
		for (int i = NT - 2; i > 0; i--) hist[i] = hist[i-1];
		hist[0] = x;
		y = fshift(acc + 16384, 15);
		energy = energy + 48'(y * y);
		rs = 0;
		rv = 0;
		if (pos + 1 >= nrd_pkg::NRD_BLOCK_SAMPLES) begin
			d = (calib < 256) ? 256 : calib;
			r = root(64'(energy) / nrd_pkg::NRD_BLOCK_SAMPLES);
			q = (r * 256 + d - 1) / d;
			rs = (q > 245) ? 8'd10 : 8'(255 - q);
			rv = 1;
			pos = 0;
			energy = '0;
			frames++;
		end else begin
			pos = (pos + 1) & 8'hff;
		end
		v = longint'(x) * 256;
		if (deemph) begin
			v = fshift(13107 * v + 52429 * longint'(de_state) + 32768, 16);
			de_state = 24'(v);
		end
		if (gain != nrd_pkg::NRD_GAIN_UNITY)
			exp_audio.push_back(16'(sat(fshift(v * longint'(gain) + 524288, 20))));
		else
			exp_audio.push_back(16'(sat(fshift(v + 128, 8))));
		exp_rssi.push_back(rs);
		exp_rv.push_back(rv);
	endfunction

	function void check_result(logic signed [15:0] a, logic [7:0] rs, logic rv);
		logic signed [15:0] ea;
		logic [7:0] er;
		logic ev;
		if (exp_audio.size() == 0) begin
			$error("unexpected result transaction");
			errors++;
			return;
		end
		ea = exp_audio.pop_front();
		er = exp_rssi.pop_front();
		ev = exp_rv.pop_front();
		if (a !== ea) begin
			$error("audio_out exp %0d got %0d", ea, a);
			errors++;
		end
		if (rs !== er) begin
			$error("rssi exp %0d got %0d", er, rs);
			errors++;
		end
		if (rv !== ev) begin
			$error("rssi_valid exp %0d got %0d", ev, rv);
			errors++;
		end
	endfunction

	function int pending();
		return exp_audio.size();
	endfunction
endclass

module tb_noise_rssi_and_deemphasis_top;
	import nrd_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [NRD_CFG_IDX_W-1:0] cfg_index;
	logic [NRD_CFG_DATA_W-1:0] cfg_data;

	sample_if in_ch ();
	result_if out_ch ();

	noise_rssi_and_deemphasis_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	nrd_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	int quiet_cycles;
	int sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction bookkeeping at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample_in);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.audio_out, out_ch.rssi, out_ch.rssi_valid);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("noise_rssi_and_deemphasis_top regression: fail");
				$finish;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_sample(logic signed [15:0] x);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= x;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(nrd_cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(200)) - 100);
			2: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
			default: return 16'($signed($urandom_range(8000)) - 4000);
		endcase
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) begin
			send_sample(rand_sample());
			sent++;
		end
	endtask

	initial begin
		logic signed [15:0] directed [$];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, alternating full scale
		send_idle_pct = 19;
		recv_idle_pct = 50;
		directed = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
			16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh5555, -16'sh5556,
			16'sh0100, -16'sh0100};
		foreach (directed[i]) begin
			send_sample(directed[i]);
			sent++;
		end
		drain();

		// small divisor below 1.0, de-emphasis on, maximum gain
		write_reg(CFG_CALIB, 16'd1);
		write_reg(CFG_DEEMPH, 16'hffff);
		write_reg(CFG_GAIN, 16'hffff);
		send_idle_pct = 19;
		recv_idle_pct = 50;
		random_run(200);
		drain();

		// largest divisor, zero gain, de-emphasis off keeps its state
		write_reg(CFG_CALIB, 16'hffff);
		write_reg(CFG_DEEMPH, 16'd0);
		write_reg(CFG_GAIN, 16'd0);
		send_idle_pct = 50;
		recv_idle_pct = 19;
		random_run(200);
		drain();

		// long receiver hold-off so the input stalls
		write_reg(CFG_CALIB, 16'd256);
		write_reg(CFG_DEEMPH, 16'd1);
		write_reg(CFG_GAIN, 16'd4095);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			random_run(180);
		join
		drain();

		write_reg(CFG_CALIB, NRD_CALIB_RESET);
		write_reg(CFG_GAIN, NRD_GAIN_UNITY);
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_CALIB, 16'($urandom_range(65535)));
			write_reg(CFG_DEEMPH, 16'($urandom_range(1)));
			write_reg(CFG_GAIN, $urandom_range(1) ? NRD_GAIN_UNITY
				: 16'($urandom_range(65535)));
			send_idle_pct = 0;
			recv_idle_pct = 0;
			random_run(190);
			drain();
		end

		$display("covered %0d samples over %0d frames, register extremes,", sent, sb.frames);
		$display("random idling on both channels and a long output hold-off");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("noise_rssi_and_deemphasis_top regression: pass");
		end else begin
			$display("noise_rssi_and_deemphasis_top regression: fail");
		end
		$finish;
	end
endmodule

/* files.f */
sv/nrd_pkg.sv
sv/nrd_if.sv
sv/nrd_front.sv
sv/nrd_queue.sv
sv/nrd_back.sv
sv/noise_rssi_and_deemphasis_top.sv
dv/tb_noise_rssi_and_deemphasis_top.sv
